/* hdl/htfd_pkg.sv */
package htfd_pkg;

  // Measurement kind carried by a reply word
  typedef enum logic {
    MEAS_TEMP = 1'b0,
    MEAS_HUM  = 1'b1
  } meas_kind_t;

  // CRC-8, x^8+x^5+x^4+1, MSB first, init 0
  localparam logic [7:0]  CrcPoly     = 8'h31;
  localparam logic [7:0]  CrcInit     = 8'h00;

  // Drop the two status bits of the raw reading
  localparam logic [15:0] StatusMask  = 16'hFFFC;

  // Conversion to tenths: (coef*raw - offs) / 2^16, temperature also / 10
  localparam logic [14:0] TempCoef    = 15'd17572;
  localparam logic [30:0] TempOffs    = 31'd307036160;
  localparam logic [14:0] HumCoef     = 15'd1250;
  localparam logic [30:0] HumOffs     = 31'd3932160;

  // Exact divide by ten for values below 43690: (x * 52429) >> 19
  localparam logic [15:0] Recip10     = 16'd52429;
  localparam int          Recip10Shift = 19;

  // One byte through the CRC register
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc_in,
                                           input logic [7:0] data);
    logic [7:0] c;
    c = crc_in ^ data;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CrcPoly;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/humidity_temp_frame_decode.sv */
// Result path: input register, stages 2 to 4, output register, then out_*.
// Throughput: one word per cycle; a five-stage pipeline with per-stage
// valid bits, stall from out_stall ripples back only through full stages.
// Reset: synchronous active-low rst_n clears all stage valid bits and
// out_valid; payload registers are not reset.
module humidity_temp_frame_decode (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic               in_func,
  input  logic [7:0]         in_data_msb,
  input  logic [7:0]         in_data_lsb,
  input  logic [7:0]         in_crc_byte,
  output logic               out_valid,
  input  logic               out_stall,
  output logic signed [11:0] out_value_tenths,
  output logic               out_crc_error
);
  import htfd_pkg::*;

  // Stage valid bits
  logic v1_r, v2_r, v3_r, v4_r, vo_r;
  // Stage ready chain
  logic rdy1, rdy2, rdy3, rdy4, rdyo;

  // Stage 1: input register
  logic       s1_func_r;
  logic [7:0] s1_msb_r, s1_lsb_r, s1_rcv_r;
  logic [7:0] s1_crc1;

  // Stage 2: first CRC byte done
  logic        s2_func_r;
  logic [15:0] s2_raw_r;
  logic [7:0]  s2_lsb_r, s2_rcv_r, s2_crc1_r;
  logic [7:0]  s2_crc2;
  logic        s2_err;
  logic [14:0] s2_coef;
  logic [30:0] s2_offs;
  logic [30:0] s2_prod;
  logic signed [31:0] s2_num;

  // Stage 3: numerator registered
  logic               s3_func_r, s3_err_r;
  logic signed [31:0] s3_num_r;
  logic [31:0]        s3_abs;
  logic [13:0]        s3_mag;
  logic [30:0]        s3_scaled;

  // Stage 4: scaled magnitude registered
  logic        s4_err_r, s4_neg_r;
  logic [30:0] s4_scaled_r;
  logic [11:0] s4_q;
  logic signed [11:0] val_nxt;

  logic signed [11:0] val_r;
  logic               err_r;

  // Ready chain: a stage takes a word when empty or when it drains
  assign rdyo = !vo_r || !out_stall;
  assign rdy4 = !v4_r || rdyo;
  assign rdy3 = !v3_r || rdy4;
  assign rdy2 = !v2_r || rdy3;
  assign rdy1 = !v1_r || rdy2;
  assign in_stall = !rdy1;

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      vo_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
      if (rdy4) v4_r <= v3_r;
      if (rdyo) vo_r <= v4_r;
    end
  end

  // Stage 1: capture the reply word, CRC over the high byte
  always_ff @(posedge clk) begin
    if (rdy1 && in_valid) begin
      s1_func_r <= in_func;
      s1_msb_r  <= in_data_msb;
      s1_lsb_r  <= in_data_lsb;
      s1_rcv_r  <= in_crc_byte;
    end
  end

  assign s1_crc1 = crc8_byte(CrcInit, s1_msb_r);

  always_ff @(posedge clk) begin
    if (rdy2 && v1_r) begin
      s2_func_r <= s1_func_r;
      s2_raw_r  <= {s1_msb_r, s1_lsb_r} & StatusMask;
      s2_lsb_r  <= s1_lsb_r;
      s2_rcv_r  <= s1_rcv_r;
      s2_crc1_r <= s1_crc1;
    end
  end

  // Stage 2: finish CRC, form the signed numerator
  assign s2_crc2 = crc8_byte(s2_crc1_r, s2_lsb_r);
  assign s2_err  = (s2_crc2 != s2_rcv_r);
  assign s2_coef = (s2_func_r == MEAS_HUM) ? HumCoef : TempCoef;
  assign s2_offs = (s2_func_r == MEAS_HUM) ? HumOffs : TempOffs;
  assign s2_prod = 31'(s2_coef * s2_raw_r);
  assign s2_num  = $signed({1'b0, s2_prod}) - $signed({1'b0, s2_offs});

  always_ff @(posedge clk) begin
    if (rdy3 && v2_r) begin
      s3_func_r <= s2_func_r;
      s3_err_r  <= s2_err;
      s3_num_r  <= s2_num;
    end
  end

  // Stage 3: magnitude over 2^16, then divide by ten for temperature
  assign s3_abs    = s3_num_r[31] ? 32'(-s3_num_r) : 32'(s3_num_r);
  assign s3_mag    = s3_abs[29:16];
  assign s3_scaled = (s3_func_r == MEAS_HUM)
                     ? {s3_mag[11:0], 19'd0}
                     : 31'(s3_mag * Recip10);

  always_ff @(posedge clk) begin
    if (rdy4 && v3_r) begin
      s4_err_r    <= s3_err_r;
      s4_neg_r    <= s3_num_r[31];
      s4_scaled_r <= s3_scaled;
    end
  end

  // Stage 4: restore sign, force zero on checksum mismatch
  assign s4_q    = s4_scaled_r[Recip10Shift +: 12];
  assign val_nxt = s4_err_r ? 12'sd0
                 : (s4_neg_r ? $signed(12'(-s4_q)) : $signed(s4_q));

  always_ff @(posedge clk) begin
    if (rdyo && v4_r) begin
      val_r <= val_nxt;
      err_r <= s4_err_r;
    end
  end

  assign out_valid        = vo_r;
  assign out_value_tenths = val_r;
  assign out_crc_error    = err_r;

endmodule

/* hdl/htfd_checker.sv */
module htfd_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               in_valid,
  input logic               in_stall,
  input logic               out_valid,
  input logic               out_stall,
  input logic signed [11:0] out_value_tenths,
  input logic               out_crc_error
);

  // A failed checksum always reports a zero reading
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_crc_error |-> out_value_tenths == 12'sd0)
    else $error("crc error word carries nonzero value");

  // A good reading stays inside the conversion range
  a_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_crc_error |->
      out_value_tenths >= -12'sd469 && out_value_tenths <= 12'sd1289)
    else $error("converted value out of range");

  // Hold a stalled result word
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=>
      out_valid && $stable(out_value_tenths) && $stable(out_crc_error))
    else $error("stalled result word changed");

  // Take an offered input word whenever the result side is free
  a_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !out_stall |-> !in_stall)
    else $error("input stalled with the result side free");

  // Reset empties the pipeline
  a_reset: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("result valid right after reset");

endmodule

bind humidity_temp_frame_decode htfd_checker u_htfd_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_valid),
  .in_stall         (in_stall),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_value_tenths (out_value_tenths),
  .out_crc_error    (out_crc_error)
);

/* sim/tb_humidity_temp_frame_decode.sv */
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decode;
  import htfd_pkg::*;

  localparam int WORDS_PER_MIX  = 350;
  localparam int NUM_DIRECTED   = 22;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int TAIL_CYCLES    = 12;
  localparam logic [7:0] POLY_LOW = 8'h31;

  // Where the checksum byte of a table row comes from
  typedef enum logic [1:0] {
    CRC_GIVEN,
    CRC_CALC,
    CRC_SPOIL
  } crc_src_t;

  typedef struct {
    meas_kind_t       kind;
    logic [7:0]       msb;
    logic [7:0]       lsb;
    logic [7:0]       crc;
    crc_src_t         src;
    bit               typed;
    logic signed [11:0] tv;
    bit               te;
  } stim_row_t;

  typedef struct {
    logic signed [11:0] value;
    logic               err;
  } reading_t;

  typedef struct {
    bit               typed;
    logic signed [11:0] value;
    logic               err;
  } tag_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic               in_func = 1'b0;
  logic [7:0]         in_data_msb = 8'h00;
  logic [7:0]         in_data_lsb = 8'h00;
  logic [7:0]         in_crc_byte = 8'h00;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic signed [11:0] out_value_tenths;
  logic               out_crc_error;

  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int results_seen = 0;
  int mismatches = 0;
  int crc_flags = 0;
  int temp_words = 0;
  int hum_words = 0;
  int quiet_cycles = 0;

  tag_t     tag_q[$];
  reading_t reading_q[$];
  stim_row_t directed_rows [NUM_DIRECTED];

  humidity_temp_frame_decode DUT (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_func          (in_func),
    .in_data_msb      (in_data_msb),
    .in_data_lsb      (in_data_lsb),
    .in_crc_byte      (in_crc_byte),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_value_tenths (out_value_tenths),
    .out_crc_error    (out_crc_error)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bitwise LFSR form of the checksum over both data bytes, init 0
  function automatic logic [7:0] reply_crc(logic [7:0] hi, logic [7:0] lo);
    logic [15:0] bits;
    logic [7:0]  r;
    logic        fb;
    bits = {hi, lo};
    r = 8'h00;
    for (int k = 15; k >= 0; k--) begin
      fb = r[7] ^ bits[k];
      r = {r[6:0], 1'b0};
      if (fb) begin
        r = r ^ POLY_LOW;
      end
    end
    return r;
  endfunction

  // Expected reading in tenths; signed divide truncates toward zero
  function automatic reading_t convert_reading(meas_kind_t kind, logic [7:0] hi,
                                               logic [7:0] lo, logic [7:0] chk);
    reading_t rd;
    longint   raw;
    longint   q;
    if (reply_crc(hi, lo) != chk) begin
      rd.value = '0;
      rd.err = 1'b1;
      return rd;
    end
    raw = longint'({hi, lo[7:2], 2'b00});
    if (kind == MEAS_TEMP) begin
      q = (17572 * raw - 64'sd307036160) / 64'sd655360;
    end else begin
      q = (1250 * raw - 64'sd3932160) / 64'sd65536;
    end
    rd.value = q[11:0];
    rd.err = 1'b0;
    return rd;
  endfunction

  task automatic flag_error(string what);
    $display("mismatch at result %0d: %s", results_seen, what);
    mismatches++;
  endtask

  // Present one reply word and hold it until the block takes it
  task automatic send_word(meas_kind_t kind, logic [7:0] m, logic [7:0] l,
                           logic [7:0] c, bit typed, logic signed [11:0] tv, bit te);
    tag_t tg;
    tg.typed = typed;
    tg.value = tv;
    tg.err = te;
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    tag_q.push_back(tg);
    in_valid    <= 1'b1;
    in_func     <= kind;
    in_data_msb <= m;
    in_data_lsb <= l;
    in_crc_byte <= c;
    @(posedge clk);
    while (in_stall) begin
      @(posedge clk);
    end
    words_sent++;
  endtask

  // Drop valid and hold off until every pending result is back
  task automatic drain();
    in_valid <= 1'b0;
    while (results_seen < words_sent) begin
      @(posedge clk);
    end
  endtask

  // Random receiver back-pressure
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < stall_pct);
  end

  // Capture accepted words, check accepted results, watch for a hang
  always @(posedge clk) begin : watch_ports
    tag_t     tg;
    reading_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        tg = tag_q.pop_front();
        want = convert_reading(meas_kind_t'(in_func), in_data_msb, in_data_lsb,
                               in_crc_byte);
        if (tg.typed) begin
          want.value = tg.value;
          want.err = tg.err;
        end
        reading_q.push_back(want);
        if (in_func == MEAS_TEMP) begin
          temp_words++;
        end else begin
          hum_words++;
        end
      end
      if (out_valid && !out_stall) begin
        results_seen++;
        if (out_crc_error) begin
          crc_flags++;
        end
        if (reading_q.size() == 0) begin
          flag_error("result word with nothing outstanding");
        end else begin
          want = reading_q.pop_front();
          if (out_value_tenths !== want.value) begin
            flag_error($sformatf("value_tenths got %0d, expected %0d",
                                 out_value_tenths, want.value));
          end
          if (out_crc_error !== want.err) begin
            flag_error($sformatf("crc_error got %0b, expected %0b",
                                 out_crc_error, want.err));
          end
        end
      end
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
        $display("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
        $display("RESULT: ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    stim_row_t  row;
    logic [7:0] m;
    logic [7:0] l;
    logic [7:0] c;
    meas_kind_t kind;
    int         pick;
    int         mix;

    // kind, msb, lsb, crc, source, typed, value, error
    directed_rows = '{
      '{MEAS_TEMP, 8'h00, 8'h00, 8'h00, CRC_GIVEN, 1, -12'sd468, 1'b0},
      '{MEAS_HUM,  8'h00, 8'h00, 8'h00, CRC_GIVEN, 1, -12'sd60,  1'b0},
      // status bits must not move the value
      '{MEAS_TEMP, 8'h00, 8'h03, 8'h00, CRC_CALC,  1, -12'sd468, 1'b0},
      '{MEAS_HUM,  8'h00, 8'h03, 8'h00, CRC_CALC,  1, -12'sd60,  1'b0},
      '{MEAS_TEMP, 8'hFF, 8'hFC, 8'h00, CRC_CALC,  1, 12'sd1288, 1'b0},
      '{MEAS_HUM,  8'hFF, 8'hFC, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_TEMP, 8'hFF, 8'hFF, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_HUM,  8'hFF, 8'hFF, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      // checksum mismatch gives zero with the flag, either kind
      '{MEAS_TEMP, 8'h00, 8'h00, 8'hFF, CRC_GIVEN, 1, 12'sd0,    1'b1},
      '{MEAS_HUM,  8'h00, 8'h00, 8'h01, CRC_GIVEN, 1, 12'sd0,    1'b1},
      '{MEAS_TEMP, 8'hFF, 8'hFF, 8'h80, CRC_SPOIL, 1, 12'sd0,    1'b1},
      '{MEAS_HUM,  8'hFF, 8'hFC, 8'h01, CRC_SPOIL, 1, 12'sd0,    1'b1},
      '{MEAS_HUM,  8'h80, 8'h01, 8'h10, CRC_SPOIL, 1, 12'sd0,    1'b1},
      // around zero, where truncation direction matters
      '{MEAS_TEMP, 8'h44, 8'h40, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_TEMP, 8'h44, 8'h44, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_TEMP, 8'h44, 8'h00, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_HUM,  8'h0C, 8'h48, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_HUM,  8'h0C, 8'h4C, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_HUM,  8'h0C, 8'h40, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_TEMP, 8'hAA, 8'h55, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_HUM,  8'h55, 8'hAA, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0},
      '{MEAS_TEMP, 8'h12, 8'h34, 8'h00, CRC_CALC,  0, 12'sd0,    1'b0}
    };

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Walk the directed table with no idling
    foreach (directed_rows[i]) begin
      row = directed_rows[i];
      c = row.crc;
      if (row.src == CRC_CALC) begin
        c = reply_crc(row.msb, row.lsb);
      end else if (row.src == CRC_SPOIL) begin
        c = reply_crc(row.msb, row.lsb) ^ row.crc;
      end
      send_word(row.kind, row.msb, row.lsb, c, row.typed, row.tv, row.te);
    end
    drain();

    // Random words under four idle and back-pressure mixes, draining after each
    for (mix = 0; mix < 4; mix++) begin
      unique case (mix)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 85; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 85; end
        default: begin idle_pct = 33; stall_pct = 33; end
      endcase
      repeat (WORDS_PER_MIX) begin
        kind = meas_kind_t'($urandom_range(0, 1));
        m = 8'($urandom_range(0, 255));
        l = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          m = ($urandom_range(0, 1) != 0) ? 8'hFF : 8'h00;
        end
        if (pick < 72) begin
          c = reply_crc(m, l);
        end else if (pick < 90) begin
          c = 8'($urandom_range(0, 255));
        end else begin
          c = reply_crc(m, l) ^ (8'h01 << $urandom_range(0, 7));
        end
        send_word(kind, m, l, c, 0, 12'sd0, 1'b0);
      end
      drain();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("Covered %0d reply words (%0d temperature, %0d humidity) over four idle mixes,",
             words_sent, temp_words, hum_words);
    $display("%0d results checked, %0d carrying the checksum flag, %0d mismatches.",
             results_seen, crc_flags, mismatches);
    if (mismatches == 0 && reading_q.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
